[rtl/rid_pkg.sv]
// ============================================================================
// rid_pkg
// Shared types and constants for the range identifier allocator.
// ============================================================================
package rid_pkg;

    // List geometry
    localparam int LIST_DEPTH = 64;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = IDX_W + 1;

    // Identifier width; one extra bit on candidates catches the wrap past all ones
    localparam int ID_W   = 16;
    localparam int CAND_W = ID_W + 1;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RANGE_FIRST   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RANGE_LAST    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IS_BACKGROUND = 2'd2;

    // Operation codes (code three is unused)
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2
    } op_t;

    typedef struct packed {
        logic [ID_W-1:0] range_first;
        logic [ID_W-1:0] range_last;
        logic            is_background;
    } cfg_t;

    typedef struct packed {
        op_t             op;
        logic            role_match;
        logic [ID_W-1:0] ident;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0] granted;
        logic            ok;
    } res_t;

endpackage

[rtl/rid_list_ram.sv]
// ============================================================================
// rid_list_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
module rid_list_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/rid_ctrl.sv]
// ============================================================================
// rid_ctrl
// Sequencer that walks the used-id list in RAM for allocate, release and query.
// ============================================================================
module rid_ctrl import rid_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  req_valid,
    output logic  req_ready,
    input  req_t  req,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST,
        ST_CHECK,
        ST_FIND,
        ST_REL,
        ST_DONE
    } state_t;

    state_t              state_reg,  state_next;
    op_t                 op_reg,     op_next;
    logic [CAND_W-1:0]   cand_reg,   cand_next;
    logic [CNT_W-1:0]    idx_reg,    idx_next;
    logic                pend_reg,   pend_next;
    logic                hit_reg,    hit_next;
    logic                dirty_reg,  dirty_next;
    logic [CNT_W-1:0]    wptr_reg,   wptr_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    res_t                res_reg,    res_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ID_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ID_W-1:0]     ram_rdata;

    logic [CNT_W-1:0]    last_idx;
    logic                more;
    logic                pass_end;
    logic                match;
    logic                cand_ok;
    logic                in_range;

    rid_list_ram #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (ID_W)
    ) u_list (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign last_idx  = count_reg - 1'b1;
    assign more      = idx_reg < count_reg;
    assign pass_end  = !more && !pend_reg;
    assign match     = pend_reg && ({1'b0, ram_rdata} == cand_reg);
    assign cand_ok   = (cand_reg != '0) && (cand_reg <= {1'b0, cfg.range_last});
    assign in_range  = (cand_reg[ID_W-1:0] >= cfg.range_first) &&
                       (cand_reg[ID_W-1:0] <= cfg.range_last);

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cand_next  = cand_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        hit_next   = hit_reg;
        dirty_next = dirty_reg;
        wptr_next  = wptr_reg;
        count_next = count_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[IDX_W-1:0];
        ram_wdata  = cand_reg[ID_W-1:0];
        ram_raddr  = idx_reg[IDX_W-1:0];

        // Stream the list out of RAM, one entry per cycle
        if (state_reg == ST_CHECK || state_reg == ST_FIND || state_reg == ST_REL) begin
            if (more) begin
                idx_next  = idx_reg + 1'b1;
                pend_next = 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    op_next    = req.op;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    dirty_next = 1'b0;
                    wptr_next  = '0;
                    cand_next  = {1'b0, req.ident};
                    res_next   = '0;
                    unique case (req.op)
                        OP_ALLOC: begin
                            if (cfg.is_background || !req.role_match ||
                                count_reg == CNT_W'(LIST_DEPTH)) begin
                                state_next = ST_DONE;
                            end else if (count_reg == '0) begin
                                cand_next  = {1'b0, cfg.range_first};
                                state_next = ST_CHECK;
                            end else begin
                                ram_raddr  = last_idx[IDX_W-1:0];
                                state_next = ST_LAST;
                            end
                        end
                        OP_RELEASE: state_next = ST_REL;
                        OP_QUERY:   state_next = ST_CHECK;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end

            ST_LAST: begin
                cand_next  = {1'b0, ram_rdata} + 1'b1;
                state_next = ST_CHECK;
            end

            ST_CHECK: begin
                if (match) begin
                    hit_next = 1'b1;
                end
                if (pass_end) begin
                    if (op_reg == OP_QUERY) begin
                        res_next.ok = hit_reg && in_range;
                        state_next  = ST_DONE;
                    end else if (cand_ok && !hit_reg) begin
                        ram_we      = 1'b1;
                        count_next  = count_reg + 1'b1;
                        res_next    = '{granted: cand_reg[ID_W-1:0], ok: 1'b1};
                        state_next  = ST_DONE;
                    end else begin
                        // Fall back to first fit from the low end, never id zero
                        cand_next  = (cfg.range_first == '0) ? CAND_W'(1)
                                                             : {1'b0, cfg.range_first};
                        idx_next   = '0;
                        dirty_next = 1'b0;
                        state_next = ST_FIND;
                    end
                end
            end

            ST_FIND: begin
                if (match) begin
                    cand_next  = cand_reg + 1'b1;
                    dirty_next = 1'b1;
                end
                if (pass_end) begin
                    if (cand_reg > {1'b0, cfg.range_last}) begin
                        state_next = ST_DONE;
                    end else if (dirty_reg) begin
                        // Candidate moved during the pass: verify it against the whole list
                        idx_next   = '0;
                        dirty_next = 1'b0;
                    end else begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        res_next   = '{granted: cand_reg[ID_W-1:0], ok: 1'b1};
                        state_next = ST_DONE;
                    end
                end
            end

            ST_REL: begin
                // Compact in place; the write pointer never passes the read pointer
                if (pend_reg && ram_rdata != cand_reg[ID_W-1:0]) begin
                    ram_we    = 1'b1;
                    ram_waddr = wptr_reg[IDX_W-1:0];
                    ram_wdata = ram_rdata;
                    wptr_next = wptr_reg + 1'b1;
                end
                if (pass_end) begin
                    count_next  = wptr_reg;
                    res_next.ok = 1'b1;
                    state_next  = ST_DONE;
                end
            end

            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        op_reg    <= op_next;
        cand_reg  <= cand_next;
        idx_reg   <= idx_next;
        hit_reg   <= hit_next;
        dirty_reg <= dirty_next;
        wptr_reg  <= wptr_next;
        res_reg   <= res_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("used count above list depth");

    a_compact_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REL && ram_we) |-> (wptr_reg < idx_reg))
        else $error("compaction write overtook read");

    a_grant_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_reg.ok && op_reg == OP_ALLOC) |->
            (res_reg.granted != '0 && res_reg.granted <= cfg.range_last))
        else $error("granted id zero or above range");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=>
            (res_valid && $stable(res_reg.granted) && $stable(res_reg.ok)))
        else $error("pending result changed");

endmodule

[rtl/range_id_allocator_unit.sv]
// ============================================================================
// range_id_allocator_unit
// Hands out identifiers from a configured range and tracks ids in use.
// ============================================================================
//
//  Channel   Direction  Ports                               Contents
//  s_        in         s_tvalid s_tready s_tdata s_tuser   one request
//  m_        out        m_tvalid m_tready m_tdata m_tuser   one response
//  cfg_      in         cfg_we cfg_addr cfg_wdata           register writes
//
//  Walk: a request takes the list walk it needs. Query and release read
//  every used entry once. Allocate reads the last entry of a non-empty
//  list, checks the candidate in one pass, and on a clash runs first-fit
//  passes over the list until one pass finds no hit or the candidate
//  runs past the range: at most count + 1 passes. The list is read
//  through the single RAM read port.
//  Reset: aresetn clears the used count and the sequencer; no RAM clear.
//  Stalls: the response sits in an output register, so a new request is
//  taken while it waits; the sequencer holds its next result until free.
//
module range_id_allocator_unit import rid_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] ident
    input  logic [2:0]            s_tuser,   // [1:0] op, [2] role_match
    // Response channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] granted
    output logic                  m_tuser,   // [0] ok
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [15:0]           cfg_wdata
);

    cfg_t  cfg_reg;
    req_t  req;
    res_t  res;
    logic  req_ready;
    logic  res_valid;
    logic  res_ready;

    logic              m_tvalid_reg;
    logic [ID_W-1:0]   m_tdata_reg;
    logic              m_tuser_reg;

    // Register file; index three has no register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_first   <= ID_W'(1);
            cfg_reg.range_last    <= ID_W'(1);
            cfg_reg.is_background <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_RANGE_FIRST:   cfg_reg.range_first   <= cfg_wdata;
                CFG_RANGE_LAST:    cfg_reg.range_last    <= cfg_wdata;
                CFG_IS_BACKGROUND: cfg_reg.is_background <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Unpack the request transaction
    assign req      = '{op: op_t'(s_tuser[1:0]), role_match: s_tuser[2], ident: s_tdata};
    assign s_tready = req_ready;

    rid_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .req_valid (s_tvalid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: load when empty or being drained in the same cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_tdata_reg <= res.granted;
            m_tuser_reg <= res.ok;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
